@@ hw/rtl/utf8_bmp_decoder_unit_defines.svh @@
// Assertion macros for the UTF-8 BMP decoder unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef UTF8_BMP_DECODER_UNIT_DEFINES_SVH
`define UTF8_BMP_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U8B_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define U8B_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/u8bmp_pkg.sv @@
// Shared types and constants for the UTF-8 BMP decoder unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8bmp_pkg;

    // result status codes
    localparam logic [2:0] ST_CHAR     = 3'd0;
    localparam logic [2:0] ST_END      = 3'd1;
    localparam logic [2:0] ST_BAD_CONT = 3'd2;
    localparam logic [2:0] ST_OVERLONG = 3'd3;
    localparam logic [2:0] ST_BAD_LEAD = 3'd4;

    // smallest legal values of multi-byte forms
    localparam logic [15:0] MIN_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;

    // decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_LEAD       = 4'b0001,
        PH_TWO_LAST   = 4'b0010,
        PH_THREE_MID  = 4'b0100,
        PH_THREE_LAST = 4'b1000
    } phase_t;

    // input word: one byte of the string
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_start;
    } in_word_t;

    // output word: one decoded result
    typedef struct packed {
        logic [15:0] code_point;
        logic [2:0]  status;
    } out_word_t;

    // decode stage to result register
    typedef struct packed {
        logic      emit;
        out_word_t word;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/u8bmp_in_stage.sv @@
// Input register of the UTF-8 BMP decoder: holds one accepted byte word.
// Depends on u8bmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8bmp_in_stage
    import u8bmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_word_t byte_word,
    input  wire logic     step,
    output logic          pend_valid,
    output in_word_t      pend_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     accept;

    // take a new word whenever the held one leaves or none is held
    assign byte_stall = valid_reg && !step;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= byte_word;
        end
    end

    assign pend_valid = valid_reg;
    assign pend_word  = word_reg;

endmodule

`default_nettype wire

@@ hw/rtl/u8bmp_decode.sv @@
// Decode stage of the UTF-8 BMP decoder: sequence state and per-byte logic.
// Depends on u8bmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8bmp_decode
    import u8bmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_word_t pend_word,
    output result_t       result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] partial_reg;
    logic [15:0] partial_next;
    logic        halted_reg;
    logic        halted_next;

    phase_t      phase_cur;
    logic [15:0] partial_cur;
    logic        halted_cur;
    logic [7:0]  b;
    logic        is_cont;
    logic [15:0] joined;

    assign b       = pend_word.data_byte;
    assign is_cont = (b[7:6] == 2'b10);
    assign joined  = partial_cur | {10'b0, b[5:0]};

    // string start clears partial sequence and halt before decoding
    always_comb
    begin
        if (pend_word.string_start)
        begin
            phase_cur   = PH_LEAD;
            partial_cur = 16'h0000;
            halted_cur  = 1'b0;
        end
        else
        begin
            phase_cur   = phase_reg;
            partial_cur = partial_reg;
            halted_cur  = halted_reg;
        end
    end

    // per-byte decode
    always_comb
    begin
        phase_next             = phase_cur;
        partial_next           = partial_cur;
        halted_next            = halted_cur;
        result.emit            = 1'b0;
        result.word.code_point = 16'h0000;
        result.word.status     = ST_CHAR;

        if (!halted_cur)
        begin
            case (phase_cur)
                PH_LEAD:
                begin
                    if (b == 8'h00)
                    begin
                        result.emit        = 1'b1;
                        result.word.status = ST_END;
                    end
                    else if (!b[7])
                    begin
                        result.emit            = 1'b1;
                        result.word.code_point = {8'h00, b};
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        partial_next = {5'b0, b[4:0], 6'b0};
                        phase_next   = PH_TWO_LAST;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        partial_next = {b[3:0], 12'b0};
                        phase_next   = PH_THREE_MID;
                    end
                    else
                    begin
                        result.emit        = 1'b1;
                        result.word.status = ST_BAD_LEAD;
                    end
                end
                PH_TWO_LAST:
                begin
                    result.emit = 1'b1;
                    if (!is_cont)
                    begin
                        result.word.status = ST_BAD_CONT;
                    end
                    else if (joined < MIN_TWO_BYTE)
                    begin
                        result.word.status = ST_OVERLONG;
                    end
                    else
                    begin
                        result.word.code_point = joined;
                    end
                    phase_next   = PH_LEAD;
                    partial_next = 16'h0000;
                end
                PH_THREE_MID:
                begin
                    if (!is_cont)
                    begin
                        result.emit        = 1'b1;
                        result.word.status = ST_BAD_CONT;
                    end
                    else
                    begin
                        partial_next = partial_cur | {4'b0, b[5:0], 6'b0};
                        phase_next   = PH_THREE_LAST;
                    end
                end
                PH_THREE_LAST:
                begin
                    result.emit = 1'b1;
                    if (!is_cont)
                    begin
                        result.word.status = ST_BAD_CONT;
                    end
                    else if (joined < MIN_THREE_BYTE)
                    begin
                        result.word.status = ST_OVERLONG;
                    end
                    else
                    begin
                        result.word.code_point = joined;
                    end
                    phase_next   = PH_LEAD;
                    partial_next = 16'h0000;
                end
                default:
                begin
                    phase_next   = PH_LEAD;
                    partial_next = 16'h0000;
                end
            endcase

            // any end or error halts and drops the partial sequence
            if (result.emit && (result.word.status != ST_CHAR))
            begin
                halted_next  = 1'b1;
                phase_next   = PH_LEAD;
                partial_next = 16'h0000;
            end
        end
    end

    // state advances only when the held word is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            partial_reg <= 16'h0000;
            halted_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/u8bmp_out_stage.sv @@
// Result register of the UTF-8 BMP decoder: holds one result word for the sink.
// Depends on u8bmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8bmp_out_stage
    import u8bmp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire result_t result,
    output logic         out_ready,
    output logic         char_valid,
    input  wire logic    char_stall,
    output out_word_t    char_word
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;
    logic      load;

    // free when empty or when the held word is taken this cycle
    assign out_ready = !valid_reg || !char_stall;
    assign load      = step && result.emit;

    always_comb
    begin
        if (out_ready)
        begin
            valid_next = load;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result.word;
        end
    end

    assign char_valid = valid_reg;
    assign char_word  = word_reg;

endmodule

`default_nettype wire

@@ hw/rtl/utf8_bmp_decoder_unit.sv @@
// UTF-8 BMP decoder unit: top level.
// Depends on u8bmp_pkg, u8bmp_in_stage, u8bmp_decode, u8bmp_out_stage.
//
// Usage:
//   Byte channel (byte_valid, byte_stall, byte_word): one UTF-8 byte per word,
//   with string_start set on the first byte of a new string.
//   Char channel (char_valid, char_stall, char_word): one result word per
//   character, end mark or error; bytes inside a sequence give no word.
//   A word moves when valid is high and stall is low at a clock edge.
//   A byte is accepted into the input register; its result goes to the result
//   register, which drives char_word (two register stages: input register,
//   result register). Throughput: one byte per cycle while the sink does not
//   stall; the decode is a single pass of shallow logic between the registers.
//   After an end or an error the unit drops bytes, giving no words, until a
//   byte with string_start set arrives.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   decoder to waiting for a lead byte, not halted.
//   When the sink stalls, the result register holds its word; one more byte
//   is held in the input register, then byte_stall rises.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_bmp_decoder_unit_defines.svh"

module utf8_bmp_decoder_unit
    import u8bmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_word_t byte_word,
    output logic          char_valid,
    input  wire logic     char_stall,
    output out_word_t     char_word
);

    logic     pend_valid;
    in_word_t pend_word;
    logic     out_ready;
    logic     step;
    result_t  result;

    // held byte is decoded when the result register can take its result
    assign step = pend_valid && out_ready;

    u8bmp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .step       (step),
        .pend_valid (pend_valid),
        .pend_word  (pend_word)
    );

    u8bmp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pend_word (pend_word),
        .result    (result)
    );

    u8bmp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .result     (result),
        .out_ready  (out_ready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    // checks
    `U8B_ASSERT_NOW(a_err_zero_cp, char_valid && (char_word.status != ST_CHAR), char_word.code_point == 16'h0000, "error or end result with nonzero code point")
    `U8B_ASSERT_NOW(a_status_legal, char_valid, char_word.status <= ST_BAD_LEAD, "result status out of range")
    `U8B_ASSERT_NOW(a_stall_cause, byte_stall, pend_valid && char_valid && char_stall, "byte stall without a full pipeline")
    `U8B_ASSERT_NEXT(a_step_loads, step && result.emit, char_valid, "emitted result did not reach the output")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf8_bmp_decoder_unit: byte words in, code point words out.
// Depends on u8bmp_pkg for the word types, status codes and decoder phases.
module testbench;
    import u8bmp_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_PERCENT  = 23;
    localparam int NOISE_PERCENT = 4;
    localparam int TARGET_BYTES  = 1620;
    localparam int MAX_PRINTED   = 100;

    // Tracks decoder state and the code point words still owed by the block
    class code_point_board;
        out_word_t   awaited_words[$];
        phase_t      phase;
        logic [15:0] partial;
        bit          halted;
        int          taken_bytes;
        int          mismatches;
        int          status_seen[5];

        function new();
            phase       = PH_LEAD;
            partial     = '0;
            halted      = 1'b0;
            taken_bytes = 0;
            mismatches  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        task report_mismatch(input string what);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        function int pending();
            return awaited_words.size();
        endfunction

        // Decode one accepted byte word; queue the word it should produce
        function void note_byte(input in_word_t w);
            logic [7:0]  b;
            logic [15:0] cp;
            bit          has_word;
            out_word_t   res;
            b        = w.data_byte;
            has_word = 1'b0;
            res      = '0;
            taken_bytes++;
            if (w.string_start)
            begin
                phase   = PH_LEAD;
                partial = '0;
                halted  = 1'b0;
            end
            if (halted)
                return;
            case (phase)
                PH_LEAD:
                begin
                    if (b == 8'h00)
                    begin
                        has_word   = 1'b1;
                        res.status = ST_END;
                    end
                    else if (!b[7])
                    begin
                        has_word       = 1'b1;
                        res.code_point = {8'h00, b};
                        res.status     = ST_CHAR;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        partial = {5'b0, b[4:0], 6'b0};
                        phase   = PH_TWO_LAST;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        partial = {b[3:0], 12'b0};
                        phase   = PH_THREE_MID;
                    end
                    else
                    begin
                        has_word   = 1'b1;
                        res.status = ST_BAD_LEAD;
                    end
                end
                PH_THREE_MID:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        has_word   = 1'b1;
                        res.status = ST_BAD_CONT;
                    end
                    else
                    begin
                        partial[11:6] = b[5:0];
                        phase         = PH_THREE_LAST;
                    end
                end
                default:
                begin
                    has_word = 1'b1;
                    cp       = partial | {10'b0, b[5:0]};
                    if (b[7:6] != 2'b10)
                        res.status = ST_BAD_CONT;
                    else if (cp < ((phase == PH_TWO_LAST) ? MIN_TWO_BYTE : MIN_THREE_BYTE))
                        res.status = ST_OVERLONG;
                    else
                    begin
                        res.code_point = cp;
                        res.status     = ST_CHAR;
                    end
                end
            endcase
            // any word closes the sequence; anything but a character halts
            if (has_word)
            begin
                phase   = PH_LEAD;
                partial = '0;
                if (res.status != ST_CHAR)
                    halted = 1'b1;
                status_seen[res.status]++;
                awaited_words.push_back(res);
            end
        endfunction

        // Compare one accepted result word with the oldest one owed
        task check_word(input out_word_t got);
            out_word_t want;
            if (awaited_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word cp=%h st=%0d",
                                          got.code_point, got.status));
            end
            else
            begin
                want = awaited_words.pop_front();
                if (got.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, wanted %h",
                                              got.code_point, want.code_point));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              got.status, want.status));
            end
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_word_t  byte_word;
    logic      char_valid;
    logic      char_stall;
    out_word_t char_word;

    code_point_board board;
    bit  steady       = 1'b0;
    bit  noisy        = 1'b0;
    bit  hold_pending = 1'b0;
    int  cycles       = 0;
    int  drain;

    // directed bytes: {string_start, data_byte}
    logic [8:0] directed_bytes [27] = '{
        {1'b1, 8'h01}, {1'b0, 8'h7F},                     // ASCII extremes
        {1'b0, 8'hC2}, {1'b0, 8'h80},                     // smallest two-byte
        {1'b0, 8'hDF}, {1'b0, 8'hBF},                     // largest two-byte
        {1'b0, 8'hEF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},      // 0xFFFF
        {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},      // surrogate passes
        {1'b0, 8'hC1}, {1'b0, 8'hBF},                     // overlong two-byte
        {1'b0, 8'h41},                                    // dropped while halted
        {1'b1, 8'hE0}, {1'b0, 8'h9F}, {1'b0, 8'hBF},      // overlong three-byte
        {1'b1, 8'h80},                                    // stray continuation
        {1'b1, 8'hF8},                                    // five-byte lead
        {1'b1, 8'hE1}, {1'b0, 8'h00},                     // NUL as continuation
        {1'b1, 8'hE0}, {1'b0, 8'hA0}, {1'b0, 8'h80},      // smallest three-byte
        {1'b0, 8'hC2}, {1'b1, 8'h00}                      // restart mid-sequence, end
    };

    utf8_bmp_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Monitor: results are checked before the same edge's input is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall)
                board.check_word(char_word);
            if (byte_valid && !byte_stall)
                board.note_byte(byte_word);
        end
    end

    // Result sink: random stalls, one long hold-off on request
    initial
    begin
        char_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                char_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            char_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Offer one byte word, sometimes swapped for a random one, with random idle cycles ahead of it
    task automatic put_byte(input logic [7:0] data, input bit first);
        in_word_t w;
        w.data_byte    = data;
        w.string_start = first;
        if (noisy && $urandom_range(99) < NOISE_PERCENT)
        begin
            w.data_byte    = 8'($urandom_range(0, 255));
            w.string_start = 1'($urandom_range(0, 1));
        end
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= w;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
    endtask

    task automatic put_two(input logic [15:0] cp, input bit first);
        put_byte({3'b110, cp[10:6]}, first);
        put_byte({2'b10, cp[5:0]}, 1'b0);
    endtask

    task automatic put_three(input logic [15:0] cp, input bit first);
        put_byte({4'b1110, cp[15:12]}, first);
        put_byte({2'b10, cp[11:6]}, 1'b0);
        put_byte({2'b10, cp[5:0]}, 1'b0);
    endtask

    // One string: mostly well-formed characters, some malformed, usually NUL-ended
    task automatic send_string();
        int          count;
        int          kind;
        logic [31:0] rnd;
        logic [7:0]  junk;
        bit          first;
        count = $urandom_range(1, 12);
        first = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            rnd  = $urandom;
            if (kind < 35)
                put_byte(8'($urandom_range(1, 127)), first);
            else if (kind < 65)
                put_two(16'($urandom_range(16'h0080, 16'h07FF)), first);
            else if (kind < 93)
                put_three(16'($urandom_range(16'h0800, 16'hFFFF)), first);
            else
            begin
                case ($urandom_range(0, 4))
                    0: put_two(16'($urandom_range(0, 16'h007F)), first);
                    1: put_three(16'($urandom_range(0, 16'h07FF)), first);
                    2:
                    begin
                        // truncated sequence
                        if (rnd[31])
                            put_byte({3'b110, rnd[4:0]}, first);
                        else
                        begin
                            put_byte({4'b1110, rnd[3:0]}, first);
                            if (rnd[30])
                                put_byte({2'b10, rnd[13:8]}, 1'b0);
                        end
                        junk = rnd[23:16];
                        if (junk[7:6] == 2'b10)
                            junk[6] = 1'b1;
                        put_byte(junk, 1'b0);
                    end
                    3: put_byte({2'b10, rnd[5:0]}, first);
                    default: put_byte(8'($urandom_range(8'hF0, 8'hFF)), first);
                endcase
            end
            first = 1'b0;
        end
        if ($urandom_range(0, 9) < 8)
            put_byte(8'h00, first);
    endtask

    // Main sequence
    initial
    begin
        board = new();
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_word  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            put_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        // random strings; the sink holds off early on to back the block up
        noisy        = 1'b1;
        hold_pending = 1'b1;
        while (board.taken_bytes < 700) send_string();
        steady = 1'b1;
        while (board.taken_bytes < 1100) send_string();
        steady = 1'b0;
        while (board.taken_bytes < TARGET_BYTES) send_string();
        byte_valid <= 1'b0;

        // drain outstanding words
        @(posedge clk);
        drain = 0;
        while (board.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d owed words never arrived",
                                            board.pending()));

        $display("Sent %0d bytes, giving %0d characters, %0d string ends and %0d errors",
                 board.taken_bytes, board.status_seen[ST_CHAR], board.status_seen[ST_END],
                 board.status_seen[ST_BAD_CONT] + board.status_seen[ST_OVERLONG]
                 + board.status_seen[ST_BAD_LEAD]);
        $display("Includes a %0d-cycle sink hold-off and a stretch with no idling",
                 HOLD_CYCLES);
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ utf8_bmp_decoder_unit.f @@
+incdir+hw/rtl
hw/rtl/u8bmp_pkg.sv
hw/rtl/u8bmp_in_stage.sv
hw/rtl/u8bmp_decode.sv
hw/rtl/u8bmp_out_stage.sv
hw/rtl/utf8_bmp_decoder_unit.sv
tb/sv/testbench.sv
